// ----- rtl/mppt_po_pkg.sv -----
// Shared constants for the perturb-and-observe MPPT duty controller.
// Holds field widths, configuration register indexes and fixed scale factors.
// Depends on nothing; used by the top level by scoped names.
`default_nettype none

package mppt_po_pkg;

  localparam int unsigned SENSE_W    = 16;
  localparam int unsigned POWER_W    = 24;
  localparam int unsigned MARGIN_W   = 7;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // 100 times the largest input voltage fits in 23 bits.
  localparam int unsigned DEN_W      = 23;
  localparam int unsigned PCT_SCALE  = 100;

  localparam logic [CFG_DATA_W-1:0] DUTY_CFG_MASK   = 16'h0FFF;
  localparam logic [CFG_DATA_W-1:0] DUTY_FULL_RESET = 16'h0FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MPPT_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_OUTPUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_MARGIN    = 3'd6;

endpackage

`default_nettype wire

// ----- rtl/mppt_perturb_observe_cccv.sv -----
// Perturb-and-observe MPPT buck duty controller with CC-CV limits.
// Decision logic, duty registers, a bit-serial divider for the predictive floor.
// Depends on mppt_po_pkg.
`default_nettype none

// One sample transfer produces one duty result. For a normal sample, the
// multiply states MUL1 and MUL2 build the floor numerator and denominator,
// then a restoring divider retires one quotient bit per cycle over the
// DUTY_BITS + 23 bit numerator, and the done state clamps and registers the
// duty once the output register is free. A sample with fault or pause set
// goes straight from its transfer to the done state. The input side stalls
// while a sample is in work, so a new sample can be taken in the same cycle
// as the result is offered; a finished result waits in the output register,
// so a new sample can be taken while it is still unread.
module mppt_perturb_observe_cccv #(
  parameter int unsigned DUTY_BITS = 12
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,

  input  wire logic                                    cfg_we_i,
  input  wire logic [mppt_po_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mppt_po_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  input  wire logic                                    in_valid_i,
  output      logic                                    in_stall_o,
  input  wire logic [mppt_po_pkg::SENSE_W-1:0]         input_voltage_i,
  input  wire logic [mppt_po_pkg::SENSE_W-1:0]         output_voltage_i,
  input  wire logic [mppt_po_pkg::SENSE_W-1:0]         output_current_i,
  input  wire logic [mppt_po_pkg::POWER_W-1:0]         input_power_i,
  input  wire logic                                    fault_i,
  input  wire logic                                    pause_i,

  output      logic                                    out_valid_o,
  input  wire logic                                    out_stall_i,
  output      logic [DUTY_BITS-1:0]                    duty_o,
  output      logic                                    buck_on_o
);

  localparam int unsigned SW    = mppt_po_pkg::SENSE_W;
  localparam int unsigned PW    = mppt_po_pkg::POWER_W;
  localparam int unsigned MW    = mppt_po_pkg::MARGIN_W;
  localparam int unsigned DENW  = mppt_po_pkg::DEN_W;
  localparam int unsigned PA_W  = MW + DUTY_BITS;
  localparam int unsigned PROD_W = PA_W + SW;
  localparam int unsigned CNT_W = $clog2(PROD_W);
  localparam int unsigned DX_W  = DUTY_BITS + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_q, state_d;

  logic                 mppt_en_q;
  logic                 charger_q;
  logic [SW-1:0]        cur_lim_q;
  logic [SW-1:0]        volt_lim_q;
  logic [DUTY_BITS-1:0] ceil_q;
  logic [DUTY_BITS-1:0] full_q;
  logic [MW-1:0]        margin_q;

  logic [DUTY_BITS-1:0] duty_q;
  logic [PW-1:0]        prev_pwr_q;
  logic [SW-1:0]        prev_vin_q;

  logic                 off_q;
  logic signed [1:0]    step_q;
  logic signed [1:0]    step_d;
  logic [SW-1:0]        vin_q;
  logic [SW-1:0]        vout_q;
  logic [PA_W-1:0]      prod_a_q;
  logic [DENW-1:0]      den_q;
  logic [PROD_W-1:0]    num_q;
  logic [DENW-1:0]      rem_q;
  logic [CNT_W-1:0]     cnt_q;

  logic                 out_valid_q;
  logic [DUTY_BITS-1:0] out_duty_q;
  logic                 out_on_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 upd_prev;
  logic [mppt_po_pkg::CFG_DATA_W-1:0] cfg_duty_val;

  logic [DENW:0]        rem_sh;
  logic [DENW:0]        rem_diff;
  logic                 q_bit;

  logic [DUTY_BITS-1:0] floor_val;
  logic signed [DX_W-1:0] d_step;
  logic signed [DX_W-1:0] d_lo;
  logic signed [DX_W-1:0] d_ceil;
  logic signed [DX_W-1:0] d_clamp;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign buck_on_o   = out_on_q;

  assign cfg_duty_val = cfg_data_i & mppt_po_pkg::DUTY_CFG_MASK;

  // Duty step decision and whether the tracking history is refreshed.
  always_comb begin
    step_d   = 2'sd0;
    upd_prev = 1'b0;
    if (output_current_i > cur_lim_q) begin
      step_d = -2'sd1;
    end else if (output_voltage_i > volt_lim_q) begin
      step_d = -2'sd1;
    end else if (!mppt_en_q) begin
      if (output_voltage_i < volt_lim_q) begin
        step_d = 2'sd1;
      end
    end else begin
      upd_prev = 1'b1;
      if (input_power_i > prev_pwr_q && input_voltage_i > prev_vin_q) begin
        step_d = -2'sd1;
      end else if (input_power_i > prev_pwr_q && input_voltage_i < prev_vin_q) begin
        step_d = 2'sd1;
      end else if (input_power_i < prev_pwr_q && input_voltage_i > prev_vin_q) begin
        step_d = 2'sd1;
      end else if (input_power_i < prev_pwr_q && input_voltage_i < prev_vin_q) begin
        step_d = -2'sd1;
      end else if (output_voltage_i < volt_lim_q) begin
        step_d = 2'sd1;
      end
    end
  end

  // One restoring division step.
  assign rem_sh   = {rem_q, num_q[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});

  // Predictive floor, step and clamp.
  always_comb begin
    if (!charger_q || den_q == '0) begin
      floor_val = '0;
    end else if (num_q > PROD_W'(ceil_q)) begin
      floor_val = ceil_q;
    end else begin
      floor_val = num_q[DUTY_BITS-1:0];
    end
    d_step = $signed({2'b00, duty_q}) + $signed({{DUTY_BITS{step_q[1]}}, step_q});
    d_lo   = $signed({2'b00, floor_val});
    d_ceil = $signed({2'b00, ceil_q});
    if (d_step < d_lo) begin
      d_clamp = d_lo;
    end else if (d_step > d_ceil) begin
      d_clamp = d_ceil;
    end else begin
      d_clamp = d_step;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (fault_i || pause_i) ? ST_DONE : ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mppt_en_q   <= 1'b1;
      charger_q   <= 1'b1;
      cur_lim_q   <= '0;
      volt_lim_q  <= '0;
      ceil_q      <= '0;
      full_q      <= mppt_po_pkg::DUTY_FULL_RESET[DUTY_BITS-1:0];
      margin_q    <= '0;
      duty_q      <= '0;
      prev_pwr_q  <= '0;
      prev_vin_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mppt_po_pkg::CFG_MPPT_ENABLE:     mppt_en_q  <= cfg_data_i[0];
          mppt_po_pkg::CFG_CHARGER_OUTPUT:  charger_q  <= cfg_data_i[0];
          mppt_po_pkg::CFG_CURRENT_LIMIT:   cur_lim_q  <= cfg_data_i[SW-1:0];
          mppt_po_pkg::CFG_VOLTAGE_LIMIT:   volt_lim_q <= cfg_data_i[SW-1:0];
          mppt_po_pkg::CFG_DUTY_CEILING:    ceil_q     <= cfg_duty_val[DUTY_BITS-1:0];
          mppt_po_pkg::CFG_DUTY_FULL_SCALE: full_q     <= cfg_duty_val[DUTY_BITS-1:0];
          mppt_po_pkg::CFG_FLOOR_MARGIN:    margin_q   <= cfg_data_i[MW-1:0];
          default: ;
        endcase
      end

      if (in_xfer && !(fault_i || pause_i) && upd_prev) begin
        prev_pwr_q <= input_power_i;
        prev_vin_q <= input_voltage_i;
      end

      if (state_q == ST_DONE && out_free) begin
        duty_q <= off_q ? '0 : d_clamp[DUTY_BITS-1:0];
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      off_q  <= fault_i || pause_i;
      step_q <= step_d;
      vin_q  <= input_voltage_i;
      vout_q <= output_voltage_i;
    end
    if (state_q == ST_MUL1) begin
      prod_a_q <= PA_W'(margin_q) * PA_W'(full_q);
      den_q    <= DENW'(vin_q) * DENW'(mppt_po_pkg::PCT_SCALE);
    end
    if (state_q == ST_MUL2) begin
      num_q <= PROD_W'(prod_a_q) * PROD_W'(vout_q);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      num_q <= {num_q[PROD_W-2:0], q_bit};
      rem_q <= q_bit ? rem_diff[DENW-1:0] : rem_sh[DENW-1:0];
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (state_q == ST_DONE && out_free) begin
      out_duty_q <= off_q ? '0 : d_clamp[DUTY_BITS-1:0];
      out_on_q   <= !off_q;
    end
  end

endmodule

`default_nettype wire
